// ===== src/vobs_pkg.sv =====
// Package: shared types, widths and codes for the view-ordered bucket sort.
`default_nettype none
package vobs_pkg;
    localparam int MAX_POINTS = 4096;
    localparam int NUM_SLICES = 128;
    localparam int AXES       = 3;
    localparam int PT_W       = $clog2(MAX_POINTS);
    localparam int CNT_W      = PT_W + 1;
    localparam int SL_W       = $clog2(NUM_SLICES);
    localparam int BK_W       = 2 * SL_W;
    localparam int CODE_W     = 7;
    localparam int DIR_W      = 16;
    localparam int SC_W       = AXES * SL_W;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_SORT  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_CLR, S_CNT_A, S_CNT_B, S_CNT_C,
        S_PFX_A, S_PFX_B, S_PLC_A, S_PLC_B, S_PLC_C
    } t_state;

    typedef struct packed {
        logic [1:0] prim;
        logic [1:0] mid;
        logic       up_p;
        logic       up_m;
    } t_view;
endpackage
`default_nettype wire

// ===== src/vobs_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module vobs_ram #(
    parameter int W  = 8,
    parameter int AW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [0:(1<<AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/vobs_axis_sel.sv =====
// Axis selection: primary and middle axis and key directions from a view vector.
`default_nettype none
module vobs_axis_sel import vobs_pkg::*; (
    input  wire logic signed [DIR_W-1:0] i_dir_x,
    input  wire logic signed [DIR_W-1:0] i_dir_y,
    input  wire logic signed [DIR_W-1:0] i_dir_z,
    output t_view                        o_view
);
    logic signed [DIR_W-1:0] dir [AXES];
    logic        [DIR_W-1:0] mag [AXES];
    logic        [1:0]       prim;
    logic        [1:0]       lst;
    logic                    have_lst;
    logic        [1:0]       mid;

    always_comb begin
        dir[0] = i_dir_x;
        dir[1] = i_dir_y;
        dir[2] = i_dir_z;
        for (int i = 0; i < AXES; i++) begin
            mag[i] = dir[i][DIR_W-1] ? DIR_W'(-dir[i]) : DIR_W'(dir[i]);
        end
        prim = 2'd0;
        for (int i = 0; i < AXES; i++) begin
            if (mag[i] >= mag[prim]) begin
                prim = 2'(i);
            end
        end
        lst      = 2'd0;
        have_lst = 1'b0;
        for (int i = 0; i < AXES; i++) begin
            if (2'(i) != prim) begin
                if (!have_lst || mag[i] <= mag[lst]) begin
                    lst = 2'(i);
                end
                have_lst = 1'b1;
            end
        end
        mid = 2'(AXES) - prim - lst;
        o_view.prim = prim;
        o_view.mid  = mid;
        o_view.up_p = !dir[prim][DIR_W-1] && (dir[prim] != '0);
        o_view.up_m = !dir[mid][DIR_W-1] && (dir[mid] != '0);
    end
endmodule
`default_nettype wire

// ===== src/view_ordered_two_key_bucket_sort.sv =====
// Top level: command sequencer over the slice, bucket-count and order memories.
// Load, clear and failed read: result one cycle after the request, next request
// at once. A good read goes through S_READ, where the registered order memory output is taken.
// Sort with N > 0 points: clear sweep of all buckets, S_CNT_A/B/C per point, then a
// prefix sweep (S_PFX_A/B) and S_PLC_A/B/C per point; no points: clear sweep only.
// Synchronous active-low reset clears counts and flags; memories are not
// cleared, the sort sweeps the bucket counts itself. The receiver cannot stall.
`default_nettype none
module view_ordered_two_key_bucket_sort import vobs_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              i_op,
    input  wire logic [CODE_W-1:0]       i_slice_x,
    input  wire logic [CODE_W-1:0]       i_slice_y,
    input  wire logic [CODE_W-1:0]       i_slice_z,
    input  wire logic signed [DIR_W-1:0] i_dir_x,
    input  wire logic signed [DIR_W-1:0] i_dir_y,
    input  wire logic signed [DIR_W-1:0] i_dir_z,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [11:0]                  o_point_index,
    output logic                         o_last_of_order
);
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_rp, n_rp;
    logic              r_ovld, n_ovld;
    logic [CNT_W-1:0]  r_p, n_p;
    logic [BK_W-1:0]   r_bk, n_bk;
    logic [CNT_W-1:0]  r_sum, n_sum;
    logic [BK_W-1:0]   r_bkt, n_bkt;
    t_view             r_view, n_view;
    logic              r_vld, n_vld;
    logic [1:0]        r_status, n_status;
    logic [11:0]       r_idx, n_idx;
    logic              r_last, n_last;

    t_view             view_in;
    logic              accept;
    t_op               op;

    logic              sc_we;
    logic [SC_W-1:0]   sc_wdata, sc_q;
    logic              bk_we;
    logic [BK_W-1:0]   bk_waddr, bk_raddr;
    logic [CNT_W-1:0]  bk_wdata, bk_q;
    logic              od_we;
    logic [PT_W-1:0]   od_raddr;
    logic [11:0]       od_q;
    logic [SL_W-1:0]   kp, km;
    logic [BK_W-1:0]   bkt_calc;

    function automatic logic [SL_W-1:0] clamp(input logic [CODE_W-1:0] c);
        logic [CODE_W:0] w;
        w = {1'b0, c};
        return (w >= (CODE_W+1)'(NUM_SLICES)) ? SL_W'(NUM_SLICES - 1) : SL_W'(c);
    endfunction

    function automatic logic [SL_W-1:0] key(input logic [SL_W-1:0] c, input logic up);
        return up ? c : SL_W'(NUM_SLICES - 1) - c;
    endfunction

    vobs_axis_sel u_axis (
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z), .o_view(view_in)
    );

    vobs_ram #(.W(SC_W), .AW(PT_W)) u_slices (
        .i_clk(i_clk), .i_we(sc_we), .i_waddr(r_cnt[PT_W-1:0]), .i_wdata(sc_wdata),
        .i_raddr(r_p[PT_W-1:0]), .o_rdata(sc_q)
    );

    vobs_ram #(.W(CNT_W), .AW(BK_W)) u_buckets (
        .i_clk(i_clk), .i_we(bk_we), .i_waddr(bk_waddr), .i_wdata(bk_wdata),
        .i_raddr(bk_raddr), .o_rdata(bk_q)
    );

    vobs_ram #(.W(12), .AW(PT_W)) u_order (
        .i_clk(i_clk), .i_we(od_we), .i_waddr(bk_q[PT_W-1:0]), .i_wdata(12'(r_p)),
        .i_raddr(od_raddr), .o_rdata(od_q)
    );

    assign busy            = (r_state != S_IDLE);
    assign accept          = start && !busy;
    assign op              = t_op'(i_op);
    assign o_valid         = r_vld;
    assign o_status        = r_status;
    assign o_point_index   = r_idx;
    assign o_last_of_order = r_last;
    assign sc_wdata        = {clamp(i_slice_z), clamp(i_slice_y), clamp(i_slice_x)};
    assign od_raddr        = r_rp[PT_W-1:0];

    always_comb begin
        kp       = key(sc_q[r_view.prim*SL_W +: SL_W], r_view.up_p);
        km       = key(sc_q[r_view.mid*SL_W +: SL_W], r_view.up_m);
        bkt_calc = {kp, km};
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rp     = r_rp;
        n_ovld   = r_ovld;
        n_p      = r_p;
        n_bk     = r_bk;
        n_sum    = r_sum;
        n_bkt    = r_bkt;
        n_view   = r_view;
        n_vld    = 1'b0;
        n_status = ST_OK;
        n_idx    = '0;
        n_last   = 1'b0;
        sc_we    = 1'b0;
        bk_we    = 1'b0;
        bk_waddr = r_bk;
        bk_wdata = '0;
        bk_raddr = r_bk;
        od_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_LOAD: begin
                            n_vld = 1'b1;
                            if (r_cnt == CNT_W'(MAX_POINTS)) begin
                                n_status = ST_FULL;
                            end else begin
                                sc_we  = 1'b1;
                                n_idx  = 12'(r_cnt);
                                n_cnt  = r_cnt + 1'b1;
                                n_ovld = 1'b0;
                                n_rp   = '0;
                            end
                        end
                        OP_SORT: begin
                            n_view  = view_in;
                            n_bk    = '0;
                            n_state = S_CLR;
                        end
                        OP_READ: begin
                            if (!r_ovld || r_rp >= r_cnt) begin
                                n_vld    = 1'b1;
                                n_status = ST_NONE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        OP_CLEAR: begin
                            n_vld  = 1'b1;
                            n_cnt  = '0;
                            n_rp   = '0;
                            n_ovld = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_vld   = 1'b1;
                n_idx   = od_q;
                n_rp    = r_rp + 1'b1;
                n_last  = (r_rp + 1'b1 == r_cnt);
                n_state = S_IDLE;
            end
            S_CLR: begin
                bk_we = 1'b1;
                n_bk  = r_bk + 1'b1;
                if (r_bk == '1) begin
                    n_p = '0;
                    if (r_cnt == '0) begin
                        n_vld   = 1'b1;
                        n_ovld  = 1'b1;
                        n_rp    = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_CNT_A;
                    end
                end
            end
            S_CNT_A: n_state = S_CNT_B;
            S_CNT_B: begin
                bk_raddr = bkt_calc;
                n_bkt    = bkt_calc;
                n_state  = S_CNT_C;
            end
            S_CNT_C: begin
                bk_we    = 1'b1;
                bk_waddr = r_bkt;
                bk_wdata = bk_q + 1'b1;
                n_p      = r_p + 1'b1;
                if (r_p + 1'b1 == r_cnt) begin
                    n_bk    = '0;
                    n_sum   = '0;
                    n_state = S_PFX_A;
                end else begin
                    n_state = S_CNT_A;
                end
            end
            S_PFX_A: n_state = S_PFX_B;
            S_PFX_B: begin
                bk_we    = 1'b1;
                bk_wdata = r_sum;
                n_sum    = r_sum + bk_q;
                n_bk     = r_bk + 1'b1;
                if (r_bk == '1) begin
                    n_p     = '0;
                    n_state = S_PLC_A;
                end else begin
                    n_state = S_PFX_A;
                end
            end
            S_PLC_A: n_state = S_PLC_B;
            S_PLC_B: begin
                bk_raddr = bkt_calc;
                n_bkt    = bkt_calc;
                n_state  = S_PLC_C;
            end
            S_PLC_C: begin
                od_we    = 1'b1;
                bk_we    = 1'b1;
                bk_waddr = r_bkt;
                bk_wdata = bk_q + 1'b1;
                n_p      = r_p + 1'b1;
                if (r_p + 1'b1 == r_cnt) begin
                    n_vld   = 1'b1;
                    n_ovld  = 1'b1;
                    n_rp    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PLC_A;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rp    <= '0;
            r_ovld  <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rp    <= n_rp;
            r_ovld  <= n_ovld;
            r_vld   <= n_vld;
        end
        r_p      <= n_p;
        r_bk     <= n_bk;
        r_sum    <= n_sum;
        r_bkt    <= n_bkt;
        r_view   <= n_view;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_last   <= n_last;
    end

    a_load_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op == OP_LOAD) |=> o_valid)
        else $error("load request gave no result");
    a_rp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= r_cnt)
        else $error("read pointer beyond point count");
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store size");
    a_last_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_order) |-> (o_status == ST_OK))
        else $error("last flag on failed result");
endmodule
`default_nettype wire

// ===== test/view_ordered_two_key_bucket_sort_tb.sv =====
// Testbench: directed table and random command sequences for the view-ordered bucket sort.
`timescale 1ns / 1ps
module view_ordered_two_key_bucket_sort_tb;
    import vobs_pkg::*;

    localparam int LIMIT_CYCLES = 8000000;

    typedef struct {
        logic [1:0]              status;
        logic [11:0]             index;
        logic                    last;
    } t_answer;

    typedef struct {
        t_op                     op;
        logic [CODE_W-1:0]       sx, sy, sz;
        logic signed [DIR_W-1:0] dx, dy, dz;
        bit                      typed;
        t_answer                 ans;
    } t_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              i_op;
    logic [CODE_W-1:0]       i_slice_x, i_slice_y, i_slice_z;
    logic signed [DIR_W-1:0] i_dir_x, i_dir_y, i_dir_z;
    logic                    o_valid;
    logic [1:0]              o_status;
    logic [11:0]             o_point_index;
    logic                    o_last_of_order;

    view_ordered_two_key_bucket_sort dut (.*);

    // predictor state
    logic [SL_W-1:0] pt_codes [MAX_POINTS][AXES];
    int              view_order [MAX_POINTS];
    int              pt_count;
    int              rd_ptr;
    bit              order_ok;

    t_answer answer_q [$];
    t_row    tbl [$];
    int      errors;
    int      cycles;
    int      n_loads, n_sorts, n_reads, n_clears, n_results;
    int      gap_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_answer w;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (answer_q.size() == 0) begin
                report("unexpected result, status", int'(o_status), -1);
            end else begin
                w = answer_q.pop_front();
                if (o_status !== w.status)
                    report("status", int'(o_status), int'(w.status));
                if (o_point_index !== w.index)
                    report("point_index", int'(o_point_index), int'(w.index));
                if (o_last_of_order !== w.last)
                    report("last_of_order", int'(o_last_of_order), int'(w.last));
            end
        end
    end

    function automatic int view_key(logic [SL_W-1:0] code, bit up);
        return up ? int'(code) : NUM_SLICES - 1 - int'(code);
    endfunction

    // stable two-key order of the loaded points
    task automatic order_points(input logic signed [DIR_W-1:0] dx, dy, dz);
        int mag [AXES];
        int dv [AXES];
        int keys [MAX_POINTS];
        int prim, lo, mid, j, p, k;
        bit up_p, up_m;
        dv[0] = int'(dx); dv[1] = int'(dy); dv[2] = int'(dz);
        for (int a = 0; a < AXES; a++) mag[a] = dv[a] < 0 ? -dv[a] : dv[a];
        prim = 0;
        for (int a = 0; a < AXES; a++) if (mag[a] >= mag[prim]) prim = a;
        lo = -1;
        for (int a = 0; a < AXES; a++) begin
            if (a != prim && (lo < 0 || mag[a] <= mag[lo])) lo = a;
        end
        mid = AXES - prim - lo;
        up_p = dv[prim] > 0;
        up_m = dv[mid] > 0;
        for (p = 0; p < pt_count; p++) begin
            k = view_key(pt_codes[p][prim], up_p) * NUM_SLICES
                + view_key(pt_codes[p][mid], up_m);
            j = p;
            while (j > 0 && keys[j-1] > k) begin
                keys[j] = keys[j-1];
                view_order[j] = view_order[j-1];
                j--;
            end
            keys[j] = k;
            view_order[j] = p;
        end
        rd_ptr = 0;
        order_ok = 1;
    endtask

    task automatic predict(input t_row r, output t_answer a);
        a = '{status: ST_OK, index: '0, last: 1'b0};
        case (r.op)
            OP_LOAD: begin
                n_loads++;
                if (pt_count >= MAX_POINTS) begin
                    a.status = ST_FULL;
                end else begin
                    pt_codes[pt_count][0] =
                        SL_W'(r.sx >= NUM_SLICES ? NUM_SLICES - 1 : int'(r.sx));
                    pt_codes[pt_count][1] =
                        SL_W'(r.sy >= NUM_SLICES ? NUM_SLICES - 1 : int'(r.sy));
                    pt_codes[pt_count][2] =
                        SL_W'(r.sz >= NUM_SLICES ? NUM_SLICES - 1 : int'(r.sz));
                    a.index = 12'(pt_count);
                    pt_count++;
                    order_ok = 0;
                    rd_ptr = 0;
                end
            end
            OP_SORT: begin
                n_sorts++;
                order_points(r.dx, r.dy, r.dz);
            end
            OP_READ: begin
                n_reads++;
                if (!order_ok || rd_ptr >= pt_count) begin
                    a.status = ST_NONE;
                end else begin
                    a.index = 12'(view_order[rd_ptr]);
                    rd_ptr++;
                    a.last = rd_ptr == pt_count;
                end
            end
            default: begin
                n_clears++;
                pt_count = 0;
                rd_ptr = 0;
                order_ok = 0;
            end
        endcase
    endtask

    // drive one request, hold it until accepted, then log its expected result
    task automatic send(input t_row r);
        t_answer a;
        start     <= 1'b1;
        i_op      <= r.op;
        i_slice_x <= r.sx;
        i_slice_y <= r.sy;
        i_slice_z <= r.sz;
        i_dir_x   <= r.dx;
        i_dir_y   <= r.dy;
        i_dir_z   <= r.dz;
        do @(posedge i_clk); while (busy);
        predict(r, a);
        answer_q.insert(answer_q.size(), r.typed ? r.ans : a);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input t_row r);
        tbl.insert(tbl.size(), r);
    endtask

    function automatic t_row cmd(t_op op, int sx = 0, int sy = 0, int sz = 0,
                                 int dx = 0, int dy = 0, int dz = 0);
        t_row r;
        r.op = op;
        r.sx = CODE_W'(sx); r.sy = CODE_W'(sy); r.sz = CODE_W'(sz);
        r.dx = DIR_W'(dx); r.dy = DIR_W'(dy); r.dz = DIR_W'(dz);
        r.typed = 0;
        r.ans = '{status: ST_OK, index: '0, last: 1'b0};
        return r;
    endfunction

    function automatic t_row typed(t_row r, logic [1:0] st, int idx = 0, bit lst = 0);
        r.typed = 1;
        r.ans = '{status: st, index: 12'(idx), last: lst};
        return r;
    endfunction

    function automatic logic signed [DIR_W-1:0] pick_dir();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3: return $urandom_range(1) ? 16'sd1 : -16'sd1;
            default: return DIR_W'($urandom);
        endcase
    endfunction

    task automatic sort_random();
        t_row r;
        r = cmd(OP_SORT, $urandom, $urandom, $urandom, pick_dir(), pick_dir(), pick_dir());
        if ($urandom_range(3) == 0) r.dy = $urandom_range(1) ? r.dx : -r.dx;
        if ($urandom_range(5) == 0) r.dz = r.dy;
        send(r);
    endtask

    task automatic random_part(input int count);
        int sent, n, rd;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                // noise: a loose request of any kind
                send(cmd(t_op'($urandom_range(3)), $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom));
                sent++;
            end else begin
                send(cmd(OP_CLEAR));
                n = $urandom_range(9) == 0 ? $urandom_range(1) : $urandom_range(50, 2);
                repeat (n) send(cmd(OP_LOAD, $urandom, $urandom, $urandom));
                sort_random();
                rd = $urandom_range(3) == 0 ? $urandom_range(n) : n + $urandom_range(2);
                repeat (rd) send(cmd(OP_READ));
                if ($urandom_range(4) == 0) begin
                    // load breaks the order; reads fail until sorted again
                    send(cmd(OP_LOAD, $urandom, $urandom, $urandom));
                    send(cmd(OP_READ));
                    sort_random();
                    repeat (n + 2) send(cmd(OP_READ));
                    sent += n + 5;
                end
                sent += n + rd + 2;
            end
        end
    endtask

    initial begin
        errors = 0; cycles = 0;
        n_loads = 0; n_sorts = 0; n_reads = 0; n_clears = 0; n_results = 0;
        pt_count = 0; rd_ptr = 0; order_ok = 0;
        gap_pct = 13;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_op = OP_LOAD;
        i_slice_x = '0; i_slice_y = '0; i_slice_z = '0;
        i_dir_x = '0; i_dir_y = '0; i_dir_z = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(typed(cmd(OP_READ), ST_NONE));
        add_row(typed(cmd(OP_SORT, 0, 0, 0, 100, 200, 300), ST_OK));
        add_row(typed(cmd(OP_READ), ST_NONE));
        add_row(typed(cmd(OP_LOAD, 0, 0, 0), ST_OK, 0));
        add_row(typed(cmd(OP_LOAD, 127, 127, 127), ST_OK, 1));
        add_row(typed(cmd(OP_LOAD, 85, 42, 1), ST_OK, 2));
        add_row(typed(cmd(OP_LOAD, 42, 85, 126), ST_OK, 3));
        add_row(typed(cmd(OP_READ), ST_NONE));
        add_row(cmd(OP_SORT, 0, 0, 0, 32767, -32768, 0));
        repeat (4) add_row(cmd(OP_READ));
        add_row(typed(cmd(OP_READ), ST_NONE));
        add_row(typed(cmd(OP_LOAD, 3, 3, 3), ST_OK, 4));
        add_row(typed(cmd(OP_READ), ST_NONE));
        add_row(cmd(OP_SORT, 0, 0, 0, -1, 1, 0));
        repeat (5) add_row(cmd(OP_READ));
        add_row(cmd(OP_SORT, 0, 0, 0, 0, 0, 0));
        repeat (2) add_row(cmd(OP_READ));
        add_row(typed(cmd(OP_CLEAR), ST_OK));
        add_row(typed(cmd(OP_READ), ST_NONE));
        foreach (tbl[i]) send(tbl[i]);

        // hold off until the block has drained
        start <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);

        // fill the point store to the top, then one load too many
        gap_pct = 0;
        for (int p = 0; p < MAX_POINTS; p++) send(cmd(OP_LOAD, $urandom, $urandom, $urandom));
        send(typed(cmd(OP_LOAD, 1, 2, 3), ST_FULL));
        send(cmd(OP_CLEAR));

        gap_pct = 13;
        random_part(450);
        gap_pct = 61;
        random_part(450);
        gap_pct = 0;
        random_part(450);

        start <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d loads, %0d sorts, %0d reads, %0d clears; %0d results checked",
                 n_loads, n_sorts, n_reads, n_clears, n_results);
        $display("store-full, reload after sort, tied and zero directions exercised");
        if (errors == 0 && answer_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
